FILE: hdl/aalu_pkg.sv
// Package for the accumulator ALU: op codes, flag and result types, DAA constants.
// Used by the interfaces, the core, the output queue and the top level.
package aalu_pkg;

   localparam int unsigned OP_W   = 4;
   localparam int unsigned DATA_W = 8;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 4'd0,
      OP_ADC  = 4'd1,
      OP_SUB  = 4'd2,
      OP_SBC  = 4'd3,
      OP_AND  = 4'd4,
      OP_XOR  = 4'd5,
      OP_OR   = 4'd6,
      OP_CP   = 4'd7,
      OP_RLCA = 4'd8,
      OP_RRCA = 4'd9,
      OP_RLA  = 4'd10,
      OP_RRA  = 4'd11,
      OP_DAA  = 4'd12,
      OP_CPL  = 4'd13,
      OP_SCF  = 4'd14,
      OP_CCF  = 4'd15
   } op_type;

   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   typedef struct packed {
      logic [DATA_W-1:0] acc;
      flags_type         flags;
   } result_type;

   localparam logic [DATA_W-1:0] DAA_ADJ_HI  = 8'h60;
   localparam logic [DATA_W-1:0] DAA_ADJ_LO  = 8'h06;
   localparam logic [DATA_W-1:0] DAA_MAX_BCD = 8'h99;
   localparam logic [3:0]        NIBBLE_MAX  = 4'h9;

endpackage

FILE: hdl/aalu_if.sv
// Valid/ready channel interfaces for the accumulator ALU request and response items.
// Depends on aalu_pkg for the field widths.
interface aalu_req_if
   import aalu_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [DATA_W-1:0] operand;

   modport source (output valid, output op, output operand, input ready);
   modport sink   (input valid, input op, input operand, output ready);
endinterface

interface aalu_rsp_if
   import aalu_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] acc_out;
   logic              flag_zero;
   logic              flag_subtract;
   logic              flag_half;
   logic              flag_carry;

   modport source (output valid, output acc_out, output flag_zero, output flag_subtract,
                   output flag_half, output flag_carry, input ready);
   modport sink   (input valid, input acc_out, input flag_zero, input flag_subtract,
                   input flag_half, input flag_carry, output ready);
endinterface

FILE: hdl/aalu_core.sv
// Combinational datapath of the accumulator ALU: one op against held accumulator and flags.
// Depends on aalu_pkg.
module aalu_core
   import aalu_pkg::*;
(
   input  op_type            op,
   input  logic [DATA_W-1:0] operand,
   input  logic [DATA_W-1:0] acc,
   input  flags_type         flags,
   output result_type        result
);

   logic              cin;
   logic [DATA_W:0]   sum;
   logic [4:0]        sum_lo;
   logic [DATA_W:0]   diff;
   logic [4:0]        diff_lo;
   logic              daa_hi;
   logic              daa_lo;
   logic [DATA_W-1:0] daa_adj;
   logic [DATA_W-1:0] daa_res;
   logic [DATA_W-1:0] r;
   flags_type         nf;

   always_comb begin
      cin     = ((op == OP_ADC) || (op == OP_SBC)) ? flags.c : 1'b0;
      sum     = {1'b0, acc} + {1'b0, operand} + {{DATA_W{1'b0}}, cin};
      sum_lo  = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'd0, cin};
      diff    = {1'b0, acc} - {1'b0, operand} - {{DATA_W{1'b0}}, cin};
      diff_lo = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'd0, cin};

      if (!flags.n) begin
         daa_hi = flags.c || (acc > DAA_MAX_BCD);
         daa_lo = flags.h || (acc[3:0] > NIBBLE_MAX);
      end else begin
         daa_hi = flags.c;
         daa_lo = flags.h;
      end
      daa_adj = (daa_hi ? DAA_ADJ_HI : '0) | (daa_lo ? DAA_ADJ_LO : '0);
      daa_res = flags.n ? (acc - daa_adj) : (acc + daa_adj);
   end

   always_comb begin
      r  = acc;
      nf = flags;
      unique case (op)
         OP_ADD, OP_ADC: begin
            r  = sum[DATA_W-1:0];
            nf = '{z: (sum[DATA_W-1:0] == '0), n: 1'b0, h: sum_lo[4], c: sum[DATA_W]};
         end
         OP_SUB, OP_SBC, OP_CP: begin
            r  = (op == OP_CP) ? acc : diff[DATA_W-1:0];
            nf = '{z: (diff[DATA_W-1:0] == '0), n: 1'b1, h: diff_lo[4], c: diff[DATA_W]};
         end
         OP_AND: begin
            r  = acc & operand;
            nf = '{z: ((acc & operand) == '0), n: 1'b0, h: 1'b1, c: 1'b0};
         end
         OP_XOR: begin
            r  = acc ^ operand;
            nf = '{z: ((acc ^ operand) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         OP_OR: begin
            r  = acc | operand;
            nf = '{z: ((acc | operand) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         OP_RLCA: begin
            r  = {acc[DATA_W-2:0], acc[DATA_W-1]};
            nf = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[DATA_W-1]};
         end
         OP_RRCA: begin
            r  = {acc[0], acc[DATA_W-1:1]};
            nf = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[0]};
         end
         OP_RLA: begin
            r  = {acc[DATA_W-2:0], flags.c};
            nf = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[DATA_W-1]};
         end
         OP_RRA: begin
            r  = {flags.c, acc[DATA_W-1:1]};
            nf = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[0]};
         end
         OP_DAA: begin
            r  = daa_res;
            nf = '{z: (daa_res == '0), n: flags.n, h: 1'b0,
                   c: (flags.n ? flags.c : daa_hi)};
         end
         OP_CPL: begin
            r  = ~acc;
            nf = '{z: flags.z, n: 1'b1, h: 1'b1, c: flags.c};
         end
         OP_SCF: begin
            nf = '{z: flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
         end
         OP_CCF: begin
            nf = '{z: flags.z, n: 1'b0, h: 1'b0, c: ~flags.c};
         end
      endcase
   end

   assign result = '{acc: r, flags: nf};

endmodule

FILE: hdl/aalu_outq.sv
// Two-entry result queue that decouples the response side from the request side.
// Depends on aalu_pkg.
module aalu_outq
   import aalu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       pop_valid,
   input  logic       pop_ready,
   output result_type pop_data
);

   result_type  q_ff [2];
   logic        wr_ptr_ff;
   logic        wr_ptr_in;
   logic        rd_ptr_ff;
   logic        rd_ptr_in;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   logic        pop;

   assign full      = count_ff[1];
   assign pop_valid = (count_ff != 2'd0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/accumulator_alu_with_flags.sv
// Top level of the accumulator ALU: accumulator and flag registers, core, result queue.
// Depends on aalu_pkg, aalu_if, aalu_core and aalu_outq.
//
//   channel  dir  modport  payload
//   req_ch   in   sink     op[3:0], operand[7:0]
//   rsp_ch   out  source   acc_out[7:0], flag_zero, flag_subtract, flag_half, flag_carry
//
// One item per cycle while the queue has room; its result reaches rsp_ch at the earliest the cycle after acceptance.
// The accumulator and flags are updated at acceptance, so the next item sees them at once.
// A two-entry result queue lets items keep flowing while a result waits; req_ch stalls
// only when both entries are held.
// Synchronous reset clears the accumulator, the flags and the queue.
module accumulator_alu_with_flags
   import aalu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   aalu_req_if.sink   req_ch,
   aalu_rsp_if.source rsp_ch
);

   logic [DATA_W-1:0] acc_ff;
   flags_type         flags_ff;
   result_type        result;
   result_type        head;
   logic              full;
   logic              accept;

   aalu_core u_core (
      .op      (op_type'(req_ch.op)),
      .operand (req_ch.operand),
      .acc     (acc_ff),
      .flags   (flags_ff),
      .result  (result)
   );

   aalu_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .full      (full),
      .pop_valid (rsp_ch.valid),
      .pop_ready (rsp_ch.ready),
      .pop_data  (head)
   );

   assign req_ch.ready = ~full;
   assign accept       = req_ch.valid && ~full;

   assign rsp_ch.acc_out       = head.acc;
   assign rsp_ch.flag_zero     = head.flags.z;
   assign rsp_ch.flag_subtract = head.flags.n;
   assign rsp_ch.flag_half     = head.flags.h;
   assign rsp_ch.flag_carry    = head.flags.c;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         flags_ff <= '0;
      end else if (accept) begin
         acc_ff   <= result.acc;
         flags_ff <= result.flags;
      end
   end

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_ch.valid)
      else $error("accepted item left no result");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid)
      else $error("request stalled with no result pending");

   a_cp_keeps_acc: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_ch.op == OP_CP)) |=> (acc_ff == $past(acc_ff)))
      else $error("compare changed the accumulator");

   a_rotate_clears_flags: assert property (@(posedge clock) disable iff (reset)
      (accept && ((req_ch.op == OP_RLCA) || (req_ch.op == OP_RRCA) ||
                  (req_ch.op == OP_RLA) || (req_ch.op == OP_RRA)))
      |=> (!flags_ff.z && !flags_ff.n && !flags_ff.h))
      else $error("rotate left Z, N or H set");

endmodule

FILE: tb/tb_accumulator_alu_with_flags.sv
// Self-checking testbench for accumulator_alu_with_flags: random and directed op items.
// Predicts accumulator and flags per item; uses aalu_pkg and the aalu_req_if/aalu_rsp_if.
`timescale 1ns / 100ps

module tb_accumulator_alu_with_flags;
   import aalu_pkg::*;

   typedef struct packed {
      op_type            op;
      logic [DATA_W-1:0] operand;
   } alu_cmd_type;

   logic clock = 1'b0;
   logic reset;

   aalu_req_if req_ch ();
   aalu_rsp_if rsp_ch ();

   accumulator_alu_with_flags dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   alu_cmd_type       cmd_q[$];
   result_type        acc_flags_due[$];
   alu_cmd_type       next_cmd;
   result_type        due;
   logic [DATA_W-1:0] acc_now   = '0;
   flags_type         flags_now = '0;
   int unsigned       total_items;
   int unsigned       accepted_count = 0;
   int unsigned       checked_count  = 0;
   int unsigned       mismatch_count = 0;
   int unsigned       daa_count      = 0;

   function automatic result_type execute_op(op_type op, logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] r;
      logic [DATA_W-1:0] diff;
      logic [DATA_W:0]   sum;
      logic [4:0]        nib;
      logic              cin;
      flags_type         f;
      flags_type         nf;
      a   = acc_now;
      f   = flags_now;
      r   = a;
      nf  = f;
      cin = 1'b0;
      case (op)
         OP_ADD, OP_ADC: begin
            if (op == OP_ADC) cin = f.c;
            sum  = {1'b0, a} + {1'b0, b} + cin;
            nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + cin;
            r    = sum[DATA_W-1:0];
            nf.z = (r == '0);
            nf.n = 1'b0;
            nf.h = nib[4];
            nf.c = sum[DATA_W];
         end
         OP_SUB, OP_SBC, OP_CP: begin
            if (op == OP_SBC) cin = f.c;
            diff = a - b - cin;
            nf.z = (diff == '0);
            nf.n = 1'b1;
            nf.h = ({1'b0, a[3:0]} < ({1'b0, b[3:0]} + cin));
            nf.c = ({1'b0, a} < ({1'b0, b} + cin));
            r    = (op == OP_CP) ? a : diff;
         end
         OP_AND, OP_XOR, OP_OR: begin
            if (op == OP_AND) r = a & b;
            else if (op == OP_XOR) r = a ^ b;
            else r = a | b;
            nf.z = (r == '0);
            nf.n = 1'b0;
            nf.h = (op == OP_AND);
            nf.c = 1'b0;
         end
         OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
            case (op)
               OP_RLCA: r = {a[6:0], a[7]};
               OP_RRCA: r = {a[0], a[7:1]};
               OP_RLA:  r = {a[6:0], f.c};
               default: r = {f.c, a[7:1]};
            endcase
            nf   = '0;
            nf.c = (op == OP_RLCA || op == OP_RLA) ? a[7] : a[0];
         end
         OP_DAA: begin
            nf.c = f.c;
            if (!f.n) begin
               if (f.c || a > DAA_MAX_BCD) begin
                  r    = r + DAA_ADJ_HI;
                  nf.c = 1'b1;
               end
               if (f.h || a[3:0] > NIBBLE_MAX) r = r + DAA_ADJ_LO;
            end else begin
               if (f.c) r = r - DAA_ADJ_HI;
               if (f.h) r = r - DAA_ADJ_LO;
            end
            nf.z = (r == '0);
            nf.n = f.n;
            nf.h = 1'b0;
         end
         OP_CPL: begin
            r    = ~a;
            nf.n = 1'b1;
            nf.h = 1'b1;
         end
         OP_SCF: begin
            nf.n = 1'b0;
            nf.h = 1'b0;
            nf.c = 1'b1;
         end
         default: begin
            nf.n = 1'b0;
            nf.h = 1'b0;
            nf.c = ~f.c;
         end
      endcase
      acc_now   = r;
      flags_now = nf;
      return {r, nf};
   endfunction

   function automatic logic [DATA_W-1:0] pick_operand();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return {4'($urandom_range(15)), 4'hF};
         3:       return {4'($urandom_range(15)), 4'h0};
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_bcd();
      return {4'($urandom_range(9)), 4'($urandom_range(9))};
   endfunction

   task automatic queue_cmd(op_type op, logic [DATA_W-1:0] operand);
      alu_cmd_type c;
      c.op      = op;
      c.operand = operand;
      cmd_q.push_back(c);
   endtask

   function automatic int unsigned send_idle_pct();
      if (accepted_count < total_items / 3) return 14;
      if (accepted_count < 2 * total_items / 3) return 46;
      return 0;
   endfunction

   function automatic int unsigned recv_stall_pct();
      if (accepted_count < total_items / 3) return 46;
      if (accepted_count < 2 * total_items / 3) return 14;
      return 0;
   endfunction

   task automatic check_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         mismatch_count++;
      end
   endtask

   // driver: advance to the next item once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.op      <= '0;
         req_ch.operand <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            acc_flags_due.push_back(execute_op(op_type'(req_ch.op), req_ch.operand));
            if (op_type'(req_ch.op) == OP_DAA) daa_count++;
            accepted_count++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
               next_cmd = cmd_q.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.op      <= next_cmd.op;
               req_ch.operand <= next_cmd.operand;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct());
   end

   // monitor: compare each result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (acc_flags_due.size() == 0) begin
            $error("unexpected result: acc_out 0x%0h", rsp_ch.acc_out);
            mismatch_count++;
         end else begin
            due = acc_flags_due.pop_front();
            check_field("acc_out", due.acc, rsp_ch.acc_out);
            check_field("flag_zero", DATA_W'(due.flags.z), DATA_W'(rsp_ch.flag_zero));
            check_field("flag_subtract", DATA_W'(due.flags.n),
                        DATA_W'(rsp_ch.flag_subtract));
            check_field("flag_half", DATA_W'(due.flags.h), DATA_W'(rsp_ch.flag_half));
            check_field("flag_carry", DATA_W'(due.flags.c), DATA_W'(rsp_ch.flag_carry));
            checked_count++;
         end
      end
   end

   initial begin
      int unsigned random_count;
      op_type      arith;
      reset = 1'b1;

      queue_cmd(OP_ADD, 8'h00);
      queue_cmd(OP_ADD, 8'hFF);
      queue_cmd(OP_ADC, 8'h01);
      queue_cmd(OP_ADC, 8'hFF);
      queue_cmd(OP_SBC, 8'h00);
      queue_cmd(OP_SUB, 8'h0F);
      queue_cmd(OP_SBC, 8'hFF);
      queue_cmd(OP_CP,  8'hF1);
      queue_cmd(OP_AND, 8'h0F);
      queue_cmd(OP_XOR, 8'h01);
      queue_cmd(OP_OR,  8'hAA);
      queue_cmd(OP_RLCA, 8'($urandom_range(255)));
      queue_cmd(OP_RRCA, 8'($urandom_range(255)));
      queue_cmd(OP_RLA,  8'($urandom_range(255)));
      queue_cmd(OP_RRA,  8'($urandom_range(255)));
      queue_cmd(OP_DAA,  8'hFF);
      queue_cmd(OP_SUB,  8'h01);
      queue_cmd(OP_DAA,  8'h00);
      queue_cmd(OP_CPL,  8'($urandom_range(255)));
      queue_cmd(OP_SCF,  8'($urandom_range(255)));
      queue_cmd(OP_CCF,  8'($urandom_range(255)));
      queue_cmd(OP_CCF,  8'($urandom_range(255)));
      queue_cmd(OP_AND,  8'h00);
      queue_cmd(OP_OR,   8'h9A);
      queue_cmd(OP_DAA,  8'($urandom_range(255)));

      random_count = 0;
      while (random_count < 1900) begin
         if ($urandom_range(3) == 0) begin
            arith = op_type'(4'($urandom_range(3)));
            queue_cmd(OP_AND, 8'h00);
            queue_cmd(OP_ADD, pick_bcd());
            queue_cmd(OP_DAA, 8'($urandom_range(255)));
            queue_cmd(arith, pick_bcd());
            queue_cmd(OP_DAA, 8'($urandom_range(255)));
            random_count += 5;
         end else begin
            queue_cmd(op_type'(4'($urandom_range(15))), pick_operand());
            random_count++;
         end
      end
      total_items = cmd_q.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items || acc_flags_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      $display("Ran %0d op items (%0d of them DAA) through three idling phases.",
               accepted_count, daa_count);
      $display("Checked %0d results, %0d field mismatches.", checked_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Run timed out with %0d items still due.", acc_flags_due.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
